>>> hw/rtl/least_connections_server_table_top_assert.svh
// Assertion macros for the least-connections server table.
// Included by the top level; no other dependencies.
`ifndef LEAST_CONNECTIONS_SERVER_TABLE_TOP_ASSERT_SVH
`define LEAST_CONNECTIONS_SERVER_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LCST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LCST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCST_ASSERT_NOW(lbl, ante, cons, msg)
`define LCST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/lcst_pkg.sv
// Shared types and constants of the least-connections server table.
// No dependencies; imported by the controller, the datapath and the top level.
package lcst_pkg;

	localparam int MAX_SERVERS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_REGISTER       = 2'd0,
		CMD_CLIENT_LEFT    = 2'd1,
		CMD_SERVER_LEAVE   = 2'd2,
		CMD_CLIENT_REQUEST = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} ctl_state_t;

	// One table entry as stored in the slot memory.
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] load;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic issue;
		logic commit;
	} dp_ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last;
		logic out_busy;
	} dp_sts_t;

endpackage

>>> hw/rtl/lcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/lcst_ctrl.sv
// Controller state machine of the server table: accept, scan, drain, finish.
// Depends on lcst_pkg.
module lcst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lcst_pkg::dp_sts_t sts,
	output lcst_pkg::dp_ctl_t ctl
);

	import lcst_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		ctl.capture = 1'b0;
		ctl.issue   = 1'b0;
		ctl.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.issue = 1'b1;
				if (sts.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/lcst_dp.sv
// Datapath of the server table: slot memory, valid bits, scan compare,
// pick register and output register. Depends on lcst_pkg and lcst_ram.
module lcst_dp #(
	parameter int MAX_SERVERS = lcst_pkg::MAX_SERVERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lcst_pkg::dp_ctl_t ctl,
	output lcst_pkg::dp_sts_t sts,
	input  logic [1:0]        command,
	input  logic [15:0]       server_id,
	input  logic [31:0]       server_addr,
	input  logic [15:0]       server_port,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [15:0]       chosen_id,
	output logic [31:0]       chosen_addr,
	output logic [15:0]       chosen_port
);

	import lcst_pkg::*;

	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	// captured transaction
	cmd_code_t   op_q;
	logic [15:0] id_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;

	// scan state
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   eval_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       pick_q;
	slot_rec_t              pick_rec_q;
	logic [MAX_SERVERS-1:0] valid_q;

	logic [REC_W-1:0] rd_data;
	slot_rec_t        rec_rd;
	logic             valid_rd;
	logic             hit;

	logic             wr_en;
	slot_rec_t        wr_rec;
	logic             set_valid;
	logic             clr_valid;
	logic             res_status;
	logic             res_chosen;

	logic             out_valid_q;

	lcst_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_SERVERS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pick_q),
		.wr_data (wr_rec),
		.rd_en   (ctl.issue),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rec_rd   = slot_rec_t'(rd_data);
	assign valid_rd = valid_q[idx_s1];

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q   <= cmd_code_t'(command);
			id_q   <= server_id;
			addr_q <= server_addr;
			port_q <= server_port;
		end
		idx_s1 <= idx_q;
		if (hit) begin
			pick_q     <= idx_s1;
			pick_rec_q <= rec_rd;
		end
	end

	// slot match for the current command
	always_comb begin
		hit = 1'b0;
		if (eval_s1) begin
			case (op_q)
				CMD_REGISTER:
					hit = !valid_rd && !found_q;
				CMD_CLIENT_LEFT, CMD_SERVER_LEAVE:
					hit = valid_rd && !found_q && (rec_rd.id == id_q);
				CMD_CLIENT_REQUEST:
					hit = valid_rd && (!found_q || (rec_rd.load < pick_rec_q.load));
				default:
					hit = 1'b0;
			endcase
		end
	end

	// table update and result at commit
	always_comb begin
		wr_en      = 1'b0;
		wr_rec     = pick_rec_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		res_status = STATUS_OK;
		res_chosen = 1'b0;
		case (op_q)
			CMD_REGISTER: begin
				wr_rec.id   = id_q;
				wr_rec.addr = addr_q;
				wr_rec.port = port_q;
				wr_rec.load = 16'd0;
				wr_en       = ctl.commit && found_q;
				set_valid   = ctl.commit && found_q;
				res_status  = found_q ? STATUS_OK : STATUS_REJECT;
			end
			CMD_CLIENT_LEFT: begin
				wr_rec.load = pick_rec_q.load - 16'd1;
				wr_en       = ctl.commit && found_q && (pick_rec_q.load != 16'd0);
			end
			CMD_SERVER_LEAVE: begin
				clr_valid = ctl.commit && found_q;
			end
			CMD_CLIENT_REQUEST: begin
				if (pick_rec_q.load != 16'hFFFF) begin
					wr_rec.load = pick_rec_q.load + 16'd1;
				end
				wr_en      = ctl.commit && found_q;
				res_status = found_q ? STATUS_OK : STATUS_REJECT;
				res_chosen = found_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			eval_s1     <= 1'b0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			eval_s1 <= ctl.issue;
			if (ctl.capture) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (ctl.issue) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (set_valid) begin
				valid_q[pick_q] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[pick_q] <= 1'b0;
			end
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status      <= res_status;
			chosen_id   <= res_chosen ? pick_rec_q.id : 16'd0;
			chosen_addr <= res_chosen ? pick_rec_q.addr : 32'd0;
			chosen_port <= res_chosen ? pick_rec_q.port : 16'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.last     = (idx_q == IDX_W'(MAX_SERVERS - 1));
	assign sts.out_busy = out_valid_q && out_stall;

endmodule

>>> hw/rtl/least_connections_server_table_top.sv
// Least-connections server table: one transaction in, one result out; a new
// transaction is accepted only after the previous one has committed. Each
// transaction is captured in the idle state, then the controller sweeps the slot
// memory one entry a cycle through its single registered read port, evaluates the
// last read in a drain state, and commits the table update and the result in a
// finish state once the output register is free. Commands: register puts
// the server in the lowest free slot with a client count of zero (status 1 when
// the table is full); client left lowers the count of the lowest slot holding the
// id, stopping at zero; server leave frees that slot; client request picks the
// valid slot with the smallest count, lowest slot on a tie, raises its count
// (stopping at 65535) and reports id, address and port (status 1 when the table
// is empty). Client left and server leave always answer ok, even for an unknown
// id. Non-request results carry zero in the chosen fields. The result sits in an
// output register; while it waits, the next transaction is accepted and scanned,
// and only its commit waits for the register to drain. Reset empties the table at
// once; there is no clearing pass.
// Depends on lcst_pkg, lcst_ctrl, lcst_dp, lcst_ram and the assertion header.
`include "least_connections_server_table_top_assert.svh"

module least_connections_server_table_top #(
	parameter int MAX_SERVERS = lcst_pkg::MAX_SERVERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] server_id,
	input  logic [31:0] server_addr,
	input  logic [15:0] server_port,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [15:0] chosen_id,
	output logic [31:0] chosen_addr,
	output logic [15:0] chosen_port
);

	import lcst_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	// Sequence each transaction: capture, sweep, drain, commit.
	lcst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Hold the table, compare each slot during the sweep, drive the result.
	lcst_dp #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.server_id   (server_id),
		.server_addr (server_addr),
		.server_port (server_port),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.chosen_id   (chosen_id),
		.chosen_addr (chosen_addr),
		.chosen_port (chosen_port)
	);

	// An accepted transaction keeps the input closed for the next cycle.
	`LCST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

	// A result appears only through a commit.
	`LCST_ASSERT_NOW(a_result_from_commit, $rose(out_valid), $past(ctl.commit), "result without commit")

	// Never overwrite a result that is still waiting.
	`LCST_ASSERT_NOW(a_no_overwrite, ctl.commit, !sts.out_busy, "commit over waiting result")

	// Capture only while the sweep is idle.
	`LCST_ASSERT_NOW(a_capture_idle, ctl.capture, !ctl.issue && !ctl.commit, "capture during sweep")

endmodule
